@@ src/rrc_pkg.sv @@
// Shared types, constants and helpers of the range rule table classifier.
// Used by rrc_rule_mem, rrc_rule_match and the top level; it depends on nothing else.
package rrc_pkg;

	localparam int NUM_RULES   = 16;
	localparam int PARAM_COUNT = 14;
	localparam int VALUE_WIDTH = 16;

	localparam int FIELD_W = 16;
	localparam int KEEP_W  = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
	localparam int RULE_W  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
	localparam int CNT_W   = $clog2(PARAM_COUNT + 1);
	localparam int SUM_W   = $clog2(PARAM_COUNT + 16);

	typedef enum logic [1:0] {
		CMD_BOUNDS = 2'd0,
		CMD_MISSES = 2'd1,
		CMD_VALUE  = 2'd2
	} cmd_t;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef logic [RULE_W-1:0] rule_idx_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         rule_index;
		logic [3:0]         param_index;
		logic signed [15:0] low_bound;
		logic signed [15:0] high_bound;
		logic [3:0]         allowed_misses;
		logic signed [15:0] param_value;
		logic [4:0]         override_code;
		logic               last_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0] matched_rule;
		logic       by_override;
		logic       no_match;
	} out_item_t;

	typedef struct packed {
		val_t lo;
		val_t hi;
	} bound_t;

	typedef bound_t [PARAM_COUNT-1:0] bound_row_t;
	typedef val_t [PARAM_COUNT-1:0] value_row_t;

	// Table write request from the control logic to the rule store.
	typedef struct packed {
		logic       bnd_we;
		logic       mis_we;
		rule_idx_t  rule;
		logic [3:0] param;
		val_t       low;
		val_t       high;
		logic [3:0] misses;
	} tbl_wr_t;

	// Keeps the low KEEP_W bits of a field and sign-extends them to VALUE_WIDTH.
	function automatic val_t to_val(input logic [FIELD_W-1:0] x);
		logic [31:0] ext;
		val_t r;
		ext = 32'(x);
		for (int b = 0; b < VALUE_WIDTH; b++) begin
			r[b] = (b < KEEP_W) ? ext[b] : x[KEEP_W-1];
		end
		return r;
	endfunction

endpackage

@@ src/rrc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package needed.
module rrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/rrc_rule_mem.sv @@
// Rule store: one bounds RAM per parameter lane, addressed by rule, plus the
// allowed-miss RAM. Uses rrc_pkg and rrc_ram.
module rrc_rule_mem (
	input  logic               clk,
	input  rrc_pkg::tbl_wr_t   wr,
	input  rrc_pkg::rule_idx_t raddr,
	output rrc_pkg::bound_row_t bounds,
	output logic [3:0]         misses
);
	import rrc_pkg::*;

	// All lanes of a rule row are read together; each lane is written on its own.
	for (genvar p = 0; p < PARAM_COUNT; p++) begin : g_lane
		logic   lane_we;
		bound_t lane_wdata;
		bound_t lane_rdata;

		assign lane_we       = wr.bnd_we && (32'(wr.param) == p);
		assign lane_wdata.lo = wr.low;
		assign lane_wdata.hi = wr.high;

		rrc_ram #(
			.WIDTH($bits(bound_t)),
			.DEPTH(NUM_RULES)
		) u_bound_ram (
			.clk  (clk),
			.we   (lane_we),
			.waddr(wr.rule),
			.wdata(lane_wdata),
			.raddr(raddr),
			.rdata(lane_rdata)
		);

		assign bounds[p] = lane_rdata;
	end

	rrc_ram #(
		.WIDTH(4),
		.DEPTH(NUM_RULES)
	) u_miss_ram (
		.clk  (clk),
		.we   (wr.mis_we),
		.waddr(wr.rule),
		.wdata(wr.misses),
		.raddr(raddr),
		.rdata(misses)
	);

endmodule

@@ src/rrc_rule_match.sv @@
// Range check of all parameter values against one rule row and the
// hit-count test against the rule's allowed misses. Uses rrc_pkg.
module rrc_rule_match (
	input  rrc_pkg::value_row_t values,
	input  rrc_pkg::bound_row_t bounds,
	input  logic [3:0]          misses,
	output logic                hit
);
	import rrc_pkg::*;

	logic [PARAM_COUNT-1:0] in_range;
	logic [CNT_W-1:0]       hits;
	logic [SUM_W-1:0]       total;

	always_comb begin
		for (int p = 0; p < PARAM_COUNT; p++) begin
			in_range[p] = ($signed(values[p]) >= $signed(bounds[p].lo)) &&
				($signed(values[p]) <= $signed(bounds[p].hi));
		end
	end

	// hits >= PARAM_COUNT - misses, rearranged so nothing goes negative.
	assign hits  = CNT_W'($countones(in_range));
	assign total = SUM_W'(hits) + SUM_W'(misses);
	assign hit   = (total >= SUM_W'(PARAM_COUNT));

endmodule

@@ src/range_rule_table_classifier_unit.sv @@
// Top level of the range rule table classifier: input decode, value registers,
// rule scan sequencer and output register. Uses rrc_pkg, rrc_rule_mem, rrc_rule_match.
//
//  Channel | Signals                          | Carries
//  --------+----------------------------------+------------------------------------
//  in      | in_valid, in_ready, in_data      | table writes and parameter values
//  out     | out_valid, out_ready, out_data   | classification result, one per last value
//
// Table writes and plain value beats are accepted whenever in_ready is high.
// A last value beat starts a scan of the rule RAMs at one rule per cycle; each rule is
// read through the registered RAM port and tested while the next is read, and the first
// hit, or the last rule with no hit, sends the result to the output register once it is
// free. in_ready is low from acceptance until the result is loaded. The output register
// holds a result until taken while new table and value beats are accepted. No clearing
// pass after reset: tables are undefined until written.
module range_rule_table_classifier_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rrc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rrc_pkg::out_item_t out_data
);
	import rrc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	localparam rule_idx_t LAST_RULE = RULE_W'(NUM_RULES - 1);

	state_t     state_q;
	rule_idx_t  scan_idx_q;
	logic       issue_q;
	logic       eval_s1;
	rule_idx_t  rule_s1;
	logic [4:0] ovr_q;
	out_item_t  res_q;
	logic       out_valid_q;
	out_item_t  out_data_q;
	value_row_t vals_q;

	logic        accept;
	logic        rule_ok;
	logic        param_ok;
	logic        start;
	logic [31:0] ri32;
	logic [31:0] rs32;
	tbl_wr_t     wr;
	bound_row_t  bounds;
	logic [3:0]  misses;
	logic        range_hit;
	logic        ovr_hit;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign rule_ok  = 32'(in_data.rule_index) < NUM_RULES;
	assign param_ok = 32'(in_data.param_index) < PARAM_COUNT;
	assign start    = accept && (in_data.cmd == CMD_VALUE) && in_data.last_value;
	assign ri32     = 32'(in_data.rule_index);
	assign rs32     = 32'(rule_s1);

	always_comb begin
		wr.bnd_we = 1'b0;
		wr.mis_we = 1'b0;
		case (in_data.cmd)
			CMD_BOUNDS: wr.bnd_we = accept && rule_ok && param_ok;
			CMD_MISSES: wr.mis_we = accept && rule_ok;
			default: ;
		endcase
		wr.rule   = ri32[RULE_W-1:0];
		wr.param  = in_data.param_index;
		wr.low    = to_val(in_data.low_bound);
		wr.high   = to_val(in_data.high_bound);
		wr.misses = in_data.allowed_misses;
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < PARAM_COUNT; p++) begin
			if (accept && (in_data.cmd == CMD_VALUE) && (32'(in_data.param_index) == p)) begin
				vals_q[p] <= to_val(in_data.param_value);
			end
		end
	end

	rrc_rule_mem u_rule_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (scan_idx_q),
		.bounds(bounds),
		.misses(misses)
	);

	rrc_rule_match u_rule_match (
		.values(vals_q),
		.bounds(bounds),
		.misses(misses),
		.hit   (range_hit)
	);

	assign ovr_hit = (32'(ovr_q) == rs32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			eval_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
						issue_q    <= 1'b1;
						eval_s1    <= 1'b0;
						ovr_q      <= in_data.override_code;
					end
				end
				ST_SCAN: begin
					// Read of rule n is issued while rule n-1 is evaluated.
					if (issue_q) begin
						scan_idx_q <= scan_idx_q + 1'b1;
						issue_q    <= (scan_idx_q != LAST_RULE);
					end
					eval_s1 <= issue_q;
					rule_s1 <= scan_idx_q;
					if (eval_s1) begin
						if (ovr_hit || range_hit) begin
							res_q.matched_rule <= rs32[3:0];
							res_q.by_override  <= ovr_hit;
							res_q.no_match     <= 1'b0;
							issue_q            <= 1'b0;
							eval_s1            <= 1'b0;
							state_q            <= ST_FINISH;
						end else if (rule_s1 == LAST_RULE) begin
							res_q.matched_rule <= 4'd0;
							res_q.by_override  <= 1'b0;
							res_q.no_match     <= 1'b1;
							issue_q            <= 1'b0;
							eval_s1            <= 1'b0;
							state_q            <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_data_q  <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_SCAN) && issue_q && (scan_idx_q == '0))
		else $error("scan did not start at rule zero");

	a_eval_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		eval_s1 |-> (state_q == ST_SCAN))
		else $error("rule evaluated outside a scan");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.bnd_we || wr.mis_we) |-> (state_q == ST_IDLE) && !eval_s1)
		else $error("table write overlaps a scan");

	a_finish_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && (!out_valid_q || out_ready))
		|=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished result not loaded into output register");

	a_no_scan_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		(eval_s1 && (rule_s1 == LAST_RULE)) |=> !eval_s1)
		else $error("scan ran past the last rule");

endmodule
